/* hw/rtl/nlss_pkg.sv */
// Shared types and constants for the nearest lower symbol search block.
`timescale 1ns / 1ps
package nlss_pkg;

  // Fixed field widths.
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;
  localparam int ADDR_W  = 32;
  localparam int TYPE_W  = 8;
  localparam int DIST_W  = 31;

  // Distance reported when no symbol matches.
  localparam logic [DIST_W-1:0] NO_MATCH_DISTANCE = 31'h7FFF_FFFF;

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes and reset values.
  localparam logic [1:0] REG_ENTRY_COUNT   = 2'd0;
  localparam logic [1:0] REG_DEBUG_MASK    = 2'd1;
  localparam logic [1:0] REG_EXTERNAL_MASK = 2'd2;
  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET   = 11'd0;
  localparam logic [TYPE_W-1:0]  DEBUG_MASK_RESET    = 8'd224;
  localparam logic [TYPE_W-1:0]  EXTERNAL_MASK_RESET = 8'd1;

  // APB address width: three registers, read back as 32-bit words, at byte offsets 0, 4 and 8.
  localparam int PADDR_W = 4;

  // One stored table entry.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TYPE_W-1:0] sym_type;
    logic              named;
  } entry_t;

  // Configuration seen by the scan logic.
  typedef struct packed {
    logic [COUNT_W-1:0] entry_count;
    logic [TYPE_W-1:0]  debug_type_mask;
    logic [TYPE_W-1:0]  external_type_mask;
  } cfg_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

/* hw/rtl/nlss_if.sv */
// Handshake channels for the request and result items.
`timescale 1ns / 1ps
interface nlss_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [9:0]  entry_index;
  logic [31:0] entry_address;
  logic [7:0]  entry_type;
  logic        entry_named;
  logic [31:0] query_address;
  logic        symbols_disabled;

  modport source (
    output valid, operation, entry_index, entry_address, entry_type, entry_named,
           query_address, symbols_disabled,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, entry_address, entry_type, entry_named,
           query_address, symbols_disabled,
    output ready
  );
endinterface

interface nlss_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [9:0]  match_index;
  logic [30:0] distance;

  modport source (output valid, found, match_index, distance, input ready);
  modport sink (input valid, found, match_index, distance, output ready);
endinterface

/* hw/rtl/nlss_cfg_regs.sv */
// APB configuration registers of the symbol search block.
`timescale 1ns / 1ps
module nlss_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nlss_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output nlss_pkg::cfg_t                 cfg
);
  import nlss_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entry_count        <= ENTRY_COUNT_RESET;
      cfg.debug_type_mask    <= DEBUG_MASK_RESET;
      cfg.external_type_mask <= EXTERNAL_MASK_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ENTRY_COUNT:   cfg.entry_count        <= pwdata[COUNT_W-1:0];
        REG_DEBUG_MASK:    cfg.debug_type_mask    <= pwdata[TYPE_W-1:0];
        REG_EXTERNAL_MASK: cfg.external_type_mask <= pwdata[TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_ENTRY_COUNT:   prdata = 32'(cfg.entry_count);
      REG_DEBUG_MASK:    prdata = 32'(cfg.debug_type_mask);
      REG_EXTERNAL_MASK: prdata = 32'(cfg.external_type_mask);
      default:           prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/nlss_table_mem.sv */
// Symbol table memory: one write port and one read port with registered data.
`timescale 1ns / 1ps
module nlss_table_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  nlss_pkg::entry_t       wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output nlss_pkg::entry_t       rdata
);
  import nlss_pkg::*;

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/nlss_scan.sv */
// Sequencer that writes table entries and scans the table for a query.
`timescale 1ns / 1ps
module nlss_scan #(
  parameter int TABLE_DEPTH = 1024,
  parameter int AW          = 10,
  parameter int CW          = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  nlss_pkg::cfg_t    cfg,
  nlss_req_if.sink          req,
  nlss_rsp_if.source        rsp,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output nlss_pkg::entry_t  mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  nlss_pkg::entry_t  mem_rdata
);
  import nlss_pkg::*;

  state_t              state, state_next;
  logic                accept, accept_query, load_out, slot_ok;
  logic [CW-1:0]       used_in;
  logic [ADDR_W-1:0]   query;
  logic [CW-1:0]       used;
  logic [CW-1:0]       issue_cnt;
  logic                rd_pending;
  logic [AW-1:0]       rd_idx;
  logic                best_found;
  logic [AW-1:0]       best_idx;
  logic [DIST_W-1:0]   best_dist;
  logic                qual, hit;
  logic [ADDR_W-1:0]   diff;

  // Entries in use, clipped to the table depth.
  assign used_in = (32'(cfg.entry_count) < TABLE_DEPTH) ? CW'(cfg.entry_count)
                                                         : CW'(TABLE_DEPTH);
  assign slot_ok = 32'(req.entry_index) < TABLE_DEPTH;

  // Table write straight from an accepted write item.
  assign mem_waddr = AW'(32'(req.entry_index));
  assign mem_wdata = '{addr: req.entry_address, sym_type: req.entry_type,
                       named: req.entry_named};
  assign mem_raddr = issue_cnt[AW-1:0];

  assign accept       = req.valid && req.ready;
  assign accept_query = accept && (req.operation == OP_QUERY);

  // Candidate check on the entry read in the previous cycle.
  assign qual = mem_rdata.named
             && ((mem_rdata.sym_type & cfg.debug_type_mask) == '0)
             && ((mem_rdata.sym_type & cfg.external_type_mask) != '0)
             && mem_rdata.addr[ADDR_W-1];
  assign diff = query - mem_rdata.addr;
  assign hit  = rd_pending && qual && (query >= mem_rdata.addr)
             && (diff < {1'b0, best_dist});

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control.
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (req.operation == OP_WRITE) begin
            mem_we = slot_ok;
          end else if (req.symbols_disabled || (used_in == '0)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        mem_re = issue_cnt < used;
        if (!mem_re && !rd_pending) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Query payload, kept for the whole scan.
  always_ff @(posedge clk) begin
    if (accept_query) begin
      query <= req.query_address;
      used  <= used_in;
    end
    if (mem_re) begin
      rd_idx <= issue_cnt[AW-1:0];
    end
  end

  // Read sequencing and best candidate tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt  <= '0;
      rd_pending <= 1'b0;
      best_found <= 1'b0;
      best_idx   <= '0;
      best_dist  <= NO_MATCH_DISTANCE;
    end else if (accept_query) begin
      issue_cnt  <= '0;
      rd_pending <= 1'b0;
      best_found <= 1'b0;
      best_idx   <= '0;
      best_dist  <= NO_MATCH_DISTANCE;
    end else begin
      rd_pending <= mem_re;
      if (mem_re) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
      if (hit) begin
        best_found <= 1'b1;
        best_idx   <= rd_idx;
        best_dist  <= diff[DIST_W-1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.found       <= best_found;
      rsp.match_index <= INDEX_W'(32'(best_idx));
      rsp.distance    <= best_dist;
    end
  end

  // A read result only arrives while scanning.
  a_pending_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> state == S_SCAN)
    else $error("table read data outside a scan");

  // The read counter never passes the number of used entries.
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> issue_cnt <= used)
    else $error("scan counter beyond used entries");

  // A missing match carries the fixed no-match answer.
  a_no_match: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.found |-> rsp.distance == NO_MATCH_DISTANCE
                                && rsp.match_index == '0)
    else $error("no-match result with stray fields");

  // A found symbol always lies strictly inside the distance limit.
  a_found_dist: assert property (@(posedge clk) disable iff (rst)
    best_found |-> best_dist != NO_MATCH_DISTANCE)
    else $error("found symbol at the distance limit");

  // A result is only loaded when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> !rsp.valid || rsp.ready)
    else $error("result overwritten before it was taken");

endmodule

/* hw/rtl/nearest_lower_symbol_search.sv */
// Nearest lower symbol search: top level with table, scan sequencer and registers.
//
// Request items on req carry an operation. A write stores address, type and
// named flag at entry_index in the symbol table and gives no result. A query
// scans entries 0 to entry_count-1 (clipped to TABLE_DEPTH) and returns one
// result item on rsp: found, match_index and distance to the qualifying symbol
// with the greatest address not above query_address. A query issues one read
// of the single table read port per used entry, compares each entry as its
// data returns and then loads the result; disabled lookups and an empty table
// skip the scan. One query is in work at a time; req.ready is high only while
// the sequencer is idle. The result sits in an output register; if rsp stalls,
// the next query still runs and waits at its end until the register is free.
// Reset clears the sequencer and the output register and sets the registers
// to their reset values; table contents are undefined until written.
// Registers are written over APB at byte offsets 0, 4 and 8; the user must
// write them only while idle, since the block itself does not enforce it.
`timescale 1ns / 1ps
module nearest_lower_symbol_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  nlss_req_if.sink                      req,
  nlss_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nlss_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import nlss_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  cfg_t          cfg;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  // Configuration registers.
  nlss_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Write and scan sequencer.
  nlss_scan #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Symbol table.
  nlss_table_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the nearest lower symbol search block.
`timescale 1ns / 1ps
module tb;
  import nlss_pkg::*;

  localparam int TABLE_DEPTH      = 1024;
  localparam int FILL_ENTRIES     = 256;
  localparam int RANDOM_ITEMS     = 280;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT      = 5000;
  localparam int SETTLE_CYCLES    = 8;

  // One request item as the sender drives it.
  typedef struct packed {
    logic        operation;
    logic [9:0]  entry_index;
    logic [31:0] entry_address;
    logic [7:0]  entry_type;
    logic        entry_named;
    logic [31:0] query_address;
    logic        symbols_disabled;
  } lookup_req_t;

  // One lookup answer.
  typedef struct packed {
    logic        found;
    logic [9:0]  match_index;
    logic [30:0] distance;
  } lookup_result_t;

  logic clk;
  logic rst = 1'b1;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  nlss_req_if req_ch ();
  nlss_rsp_if rsp_ch ();

  nearest_lower_symbol_search #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Shadow copy of the symbol table and the registers.
  entry_t         sym_table [TABLE_DEPTH];
  cfg_t           model_cfg;
  lookup_result_t pending_lookups [$];

  int mismatch_count = 0;
  bit drain_stuck    = 1'b0;
  bit req_gaps_on    = 1'b1;
  bit rsp_stalls_on  = 1'b1;
  int rsp_long_hold  = 0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Overall run limit.
  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // Nearest qualifying symbol at or below the query address, lowest slot on a tie.
  function automatic lookup_result_t nearest_symbol(input logic [31:0] query,
                                                    input logic disabled);
    lookup_result_t r;
    entry_t         e;
    int             used;
    int             i;
    logic [31:0]    d;
    logic [31:0]    best_d;
    r.found       = 1'b0;
    r.match_index = '0;
    best_d        = 32'h7FFF_FFFF;
    used = (model_cfg.entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(model_cfg.entry_count);
    if (!disabled) begin
      for (i = 0; i < used; i++) begin
        e = sym_table[i];
        if (e.named && ((e.sym_type & model_cfg.debug_type_mask) == '0) &&
            ((e.sym_type & model_cfg.external_type_mask) != '0) &&
            e.addr[31] && (query >= e.addr)) begin
          d = query - e.addr;
          if (d < best_d) begin
            best_d        = d;
            r.found       = 1'b1;
            r.match_index = 10'(i);
          end
        end
      end
    end
    r.distance = r.found ? best_d[30:0] : NO_MATCH_DISTANCE;
    return r;
  endfunction

  function automatic lookup_req_t make_write(input logic [9:0] slot, input logic [31:0] addr,
                                             input logic [7:0] sym_type, input logic named);
    lookup_req_t it;
    it.operation        = OP_WRITE;
    it.entry_index      = slot;
    it.entry_address    = addr;
    it.entry_type       = sym_type;
    it.entry_named      = named;
    it.query_address    = $urandom;
    it.symbols_disabled = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic lookup_req_t make_query(input logic [31:0] addr, input logic disabled);
    lookup_req_t it;
    it.operation        = OP_QUERY;
    it.entry_index      = 10'($urandom_range(0, 1023));
    it.entry_address    = $urandom;
    it.entry_type       = 8'($urandom_range(0, 255));
    it.entry_named      = 1'($urandom_range(0, 1));
    it.query_address    = addr;
    it.symbols_disabled = disabled;
    return it;
  endfunction

  // Offer one item, wait for it to be taken, then update the shadow state.
  task automatic send_item(input lookup_req_t it);
    int gap;
    gap = req_gaps_on ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid            <= 1'b1;
    req_ch.operation        <= it.operation;
    req_ch.entry_index      <= it.entry_index;
    req_ch.entry_address    <= it.entry_address;
    req_ch.entry_type       <= it.entry_type;
    req_ch.entry_named      <= it.entry_named;
    req_ch.query_address    <= it.query_address;
    req_ch.symbols_disabled <= it.symbols_disabled;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    if (it.operation == OP_WRITE) begin
      sym_table[it.entry_index] = '{addr: it.entry_address, sym_type: it.entry_type,
                                    named: it.entry_named};
    end else begin
      pending_lookups.push_back(nearest_symbol(it.query_address, it.symbols_disabled));
    end
  endtask

  // Stop offering items, wait for every outstanding answer, then let the block settle.
  task automatic wait_for_results();
    int waited;
    @(negedge clk);
    req_ch.valid <= 1'b0;
    waited = 0;
    while (pending_lookups.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_lookups.size() != 0) begin
      drain_stuck = 1'b1;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write a register over APB once the block is idle, then read it back.
  task automatic set_register(input logic [1:0] reg_idx, input logic [31:0] value);
    logic [31:0] mask;
    logic [31:0] got;
    case (reg_idx)
      REG_ENTRY_COUNT: mask = 32'h0000_07FF;
      default:         mask = 32'h0000_00FF;
    endcase
    wait_for_results();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= (value & mask) | ($urandom & ~mask);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    case (reg_idx)
      REG_ENTRY_COUNT:   model_cfg.entry_count        = value[COUNT_W-1:0];
      REG_DEBUG_MASK:    model_cfg.debug_type_mask    = value[TYPE_W-1:0];
      REG_EXTERNAL_MASK: model_cfg.external_type_mask = value[TYPE_W-1:0];
      default: ;
    endcase
    // Read back in a second transfer.
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((got & mask) !== (value & mask)) begin
      note_mismatch($sformatf("register %0d readback: expected 0x%0h, got 0x%0h",
                              reg_idx, value & mask, got & mask));
    end
  endtask

  // Result receiver: random stalls per item, plus one long hold on request.
  initial begin : rsp_receiver
    int stall;
    rsp_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      stall = rsp_stalls_on ? $urandom_range(0, 4) : 0;
      if (rsp_long_hold > 0) begin
        stall         = rsp_long_hold;
        rsp_long_hold = 0;
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (rsp_ch.valid !== 1'b1) @(posedge clk);
    end
  end

  // Compare every accepted answer with the oldest pending one.
  always @(posedge clk) begin : check_results
    lookup_result_t exp_r;
    lookup_result_t got_r;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got_r = '{found: rsp_ch.found, match_index: rsp_ch.match_index,
                distance: rsp_ch.distance};
      if (pending_lookups.size() == 0) begin
        note_mismatch($sformatf("unexpected answer: found=%0d index=%0d distance=%0d",
                                got_r.found, got_r.match_index, got_r.distance));
      end else begin
        exp_r = pending_lookups.pop_front();
        if (got_r.found !== exp_r.found || got_r.match_index !== exp_r.match_index ||
            got_r.distance !== exp_r.distance) begin
          note_mismatch($sformatf(
              "answer mismatch: expected found=%0d index=%0d distance=%0d, got %0d %0d %0d",
              exp_r.found, exp_r.match_index, exp_r.distance,
              got_r.found, got_r.match_index, got_r.distance));
        end
      end
    end
  end

  // Queries on the empty table after reset.
  task automatic test_empty_table();
    send_item(make_query(32'hFFFF_FFFF, 1'b0));
    send_item(make_query(32'h0000_0000, 1'b0));
    send_item(make_query(32'h8000_0000, 1'b1));
    wait_for_results();
  endtask

  // Fill the lower part of the table, then scan all of the filled entries.
  task automatic test_large_table();
    int          i;
    logic [31:0] addr;
    for (i = 0; i < FILL_ENTRIES; i++) begin
      addr = $urandom;
      if (i % 16 == 0) begin
        // Every sixteenth entry qualifies under the reset masks.
        send_item(make_write(10'(i), addr | 32'h8000_0000, 8'h01, 1'b1));
      end else begin
        send_item(make_write(10'(i), addr, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1))));
      end
    end
    set_register(REG_ENTRY_COUNT, 32'(FILL_ENTRIES));
    send_item(make_query({1'b1, 31'($urandom)}, 1'b0));
    send_item(make_query(32'hFFFF_FFFF, 1'b0));
    send_item(make_query(sym_table[FILL_ENTRIES - 16].addr, 1'b0));
    send_item(make_query(32'hFFFF_FFFF, 1'b1));
    wait_for_results();
  endtask

  // Hand-built table: skipped kinds of entries, ties, exact hits and the distance limit.
  task automatic test_directed_cases();
    set_register(REG_ENTRY_COUNT, 32'd8);
    send_item(make_write(10'd0, 32'h8000_0000, 8'h01, 1'b1));
    send_item(make_write(10'd1, 32'h8000_1000, 8'h01, 1'b1));
    send_item(make_write(10'd2, 32'h8000_1000, 8'h01, 1'b1));
    send_item(make_write(10'd3, 32'h8000_2000, 8'h21, 1'b1));
    send_item(make_write(10'd4, 32'h8000_3000, 8'h02, 1'b1));
    send_item(make_write(10'd5, 32'h8000_4000, 8'h01, 1'b0));
    send_item(make_write(10'd6, 32'h0000_5000, 8'h01, 1'b1));
    send_item(make_write(10'd7, 32'hFFFF_FFFF, 8'h01, 1'b1));
    send_item(make_query(32'h8000_1000, 1'b0));
    send_item(make_query(32'h8000_1FFF, 1'b0));
    send_item(make_query(32'h8000_3500, 1'b0));
    send_item(make_query(32'h8000_4800, 1'b0));
    send_item(make_query(32'h7FFF_FFFF, 1'b0));
    send_item(make_query(32'h8000_0000, 1'b0));
    send_item(make_query(32'hFFFF_FFFF, 1'b0));
    send_item(make_query(32'hFFFF_FFFE, 1'b0));
    send_item(make_query(32'h8000_1000, 1'b1));
    // Only the symbol at the bottom of kernel space is left in use.
    set_register(REG_ENTRY_COUNT, 32'd1);
    send_item(make_query(32'hFFFF_FFFF, 1'b0));
    send_item(make_query(32'hFFFF_FFFE, 1'b0));
    wait_for_results();
  endtask

  // Debug and external masks decide which entries qualify.
  task automatic test_type_masks();
    set_register(REG_ENTRY_COUNT, 32'd8);
    set_register(REG_DEBUG_MASK, 32'd0);
    send_item(make_query(32'h8000_2800, 1'b0));
    set_register(REG_EXTERNAL_MASK, 32'h02);
    send_item(make_query(32'h8000_3500, 1'b0));
    set_register(REG_EXTERNAL_MASK, 32'h00);
    send_item(make_query(32'h8000_3500, 1'b0));
    set_register(REG_DEBUG_MASK, 32'hFF);
    set_register(REG_EXTERNAL_MASK, 32'hFF);
    send_item(make_query(32'hFFFF_FFFF, 1'b0));
    set_register(REG_DEBUG_MASK, 32'(DEBUG_MASK_RESET));
    set_register(REG_EXTERNAL_MASK, 32'(EXTERNAL_MASK_RESET));
    wait_for_results();
  endtask

  // The receiver holds off while queries keep coming, so the block backs up.
  task automatic test_back_pressure();
    int k;
    set_register(REG_ENTRY_COUNT, 32'd16);
    req_gaps_on   = 1'b0;
    rsp_long_hold = LONG_HOLD_CYCLES;
    for (k = 0; k < 8; k++) begin
      send_item(make_query((k % 2 == 0) ? {1'b1, 31'($urandom)} : $urandom, 1'b0));
    end
    wait_for_results();
    req_gaps_on = 1'b1;
  endtask

  // Rounds of small tables near a base address with mostly qualifying entries.
  task automatic test_random_traffic();
    int          sent;
    int          count;
    int          n;
    int          k;
    int          kind;
    int          slot;
    logic [31:0] base;
    logic [31:0] addr;
    logic [7:0]  sym_type;
    logic [7:0]  skip_mask;
    logic [7:0]  ext;
    lookup_req_t it;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // Pick the register settings for this round.
      case ($urandom_range(0, 15))
        0:       count = 0;
        1, 2:    count = $urandom_range(25, 64);
        default: count = $urandom_range(1, 24);
      endcase
      case ($urandom_range(0, 9))
        0:       skip_mask = 8'h00;
        1:       skip_mask = 8'hFF;
        2, 3:    skip_mask = 8'($urandom_range(0, 255));
        default: skip_mask = DEBUG_MASK_RESET;
      endcase
      case ($urandom_range(0, 9))
        0:       ext = 8'h00;
        1:       ext = 8'hFF;
        2:       ext = 8'($urandom_range(0, 255));
        3:       ext = 8'(1 << $urandom_range(0, 7));
        default: ext = EXTERNAL_MASK_RESET;
      endcase
      set_register(REG_ENTRY_COUNT, 32'(count));
      set_register(REG_DEBUG_MASK, 32'(skip_mask));
      set_register(REG_EXTERNAL_MASK, 32'(ext));
      req_gaps_on   = ($urandom_range(0, 3) != 0);
      rsp_stalls_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0:       base = $urandom;
        1:       base = 32'hFFFF_0000 | 32'($urandom_range(0, 'hFFFF));
        2:       base = 32'h8000_0000 | 32'($urandom_range(0, 'hFFFF));
        default: base = {1'b1, 31'($urandom)};
      endcase
      n = $urandom_range(8, 30);
      for (k = 0; k < n; k++) begin
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
          // Table write, mostly a qualifying entry inside the used range.
          if (count > 0 && $urandom_range(0, 9) != 0) begin
            slot = $urandom_range(0, count - 1);
          end else begin
            slot = $urandom_range(0, TABLE_DEPTH - 1);
          end
          addr = ($urandom_range(0, 4) != 0) ? base + 32'($urandom_range(0, 'hFFFF))
                                              : $urandom;
          sym_type = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 4) != 0) begin
            sym_type = (sym_type & ~model_cfg.debug_type_mask) |
                       (model_cfg.external_type_mask & ~model_cfg.debug_type_mask);
          end
          it = make_write(10'(slot), addr, sym_type, ($urandom_range(0, 9) != 0));
        end else if (kind < 85) begin
          // Query near the entries, exactly on one, or anywhere.
          case ($urandom_range(0, 9))
            0, 1, 2: begin
              addr = (count > 0) ? sym_table[$urandom_range(0, count - 1)].addr : base;
            end
            3, 4:    addr = $urandom;
            default: addr = base + 32'($urandom_range(0, 'h1FFFF)) - 32'h800;
          endcase
          it = make_query(addr, ($urandom_range(0, 9) == 0));
        end else begin
          // Noise: every field random.
          it = $urandom_range(0, 1) ? make_query($urandom, 1'($urandom_range(0, 1)))
                                    : make_write(10'($urandom_range(0, 1023)), $urandom,
                                                 8'($urandom_range(0, 255)),
                                                 1'($urandom_range(0, 1)));
        end
        send_item(it);
      end
      sent += n;
    end
    wait_for_results();
    req_gaps_on   = 1'b1;
    rsp_stalls_on = 1'b1;
  endtask

  // Reset, run the tests in turn, then report.
  initial begin
    int i;
    req_ch.valid            = 1'b0;
    req_ch.operation        = OP_WRITE;
    req_ch.entry_index      = '0;
    req_ch.entry_address    = '0;
    req_ch.entry_type       = '0;
    req_ch.entry_named      = 1'b0;
    req_ch.query_address    = '0;
    req_ch.symbols_disabled = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      sym_table[i] = '0;
    end
    model_cfg = '{entry_count: ENTRY_COUNT_RESET, debug_type_mask: DEBUG_MASK_RESET,
                  external_type_mask: EXTERNAL_MASK_RESET};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_large_table();
    test_directed_cases();
    test_type_masks();
    test_back_pressure();
    test_random_traffic();
    wait_for_results();

    if (mismatch_count == 0 && !drain_stuck && pending_lookups.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
